// ===== rtl/cau_pkg.sv =====
package cau_pkg;

	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_MOD  = 3'd4,
		OP_SQRT = 3'd5,
		OP_POW  = 3'd6,
		OP_NOP  = 3'd7
	} cau_op_t;

	// front-end classification: done in the front or handed to the sequencer
	typedef enum logic {
		K_DIRECT = 1'b0,
		K_ITER   = 1'b1
	} cau_kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DIVN,
		S_DIVRE,
		S_DIVIM,
		S_NORM,
		S_SQM,
		S_SQRE,
		S_SQIMD,
		S_SQIMS,
		S_PWSQ,
		S_PWMA
	} cau_state_t;

	typedef struct packed {
		cau_op_t            opcode;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
		logic signed [7:0]  exponent;
	} cau_item_t;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic signed [31:0] alt_re;
		logic signed [31:0] alt_im;
		logic               status;
	} cau_result_t;

	// queue entry between front and back
	typedef struct packed {
		cau_kind_t          kind;
		cau_op_t            op;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
		logic [7:0]         pow_n;
		logic               pow_neg;
		logic signed [31:0] qk_re;
		logic signed [31:0] qk_im;
	} cau_entry_t;

	typedef struct packed {
		logic idle;
		logic pop;
	} cau_xstat_t;

	// clamp a wide signed value to the 32-bit range
	function automatic logic signed [31:0] sat_w66(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = SAT_MAX;
		end else if (v < -66'sd2147483648) begin
			r = SAT_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// signed, saturated quotient from magnitude and overflow flag
	function automatic logic signed [31:0] sat_quot(input logic ovf, input logic neg,
			input logic [31:0] q);
		logic signed [65:0] v;
		logic signed [31:0] r;
		v = $signed({34'd0, q});
		if (neg) begin
			v = -v;
		end
		if (ovf) begin
			r = neg ? SAT_MIN : SAT_MAX;
		end else begin
			r = sat_w66(v);
		end
		return r;
	endfunction

	function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
		logic signed [31:0] r;
		if (v == SAT_MIN) begin
			r = SAT_MAX;
		end else begin
			r = -v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/cau_front.sv =====
module cau_front import cau_pkg::*; (
	input  logic       start,
	input  logic       full,
	input  cau_item_t  cmd,
	output logic       push,
	output cau_entry_t entry
);

	logic signed [32:0] sum;
	logic signed [32:0] dif;

	assign push = start & ~full;

	// add, subtract and no-op finish here; the rest go to the sequencer
	assign sum = 33'(cmd.a_re) + 33'(cmd.b_re);
	assign dif = 33'(cmd.a_re) - 33'(cmd.b_re);

	logic signed [32:0] sum_i;
	logic signed [32:0] dif_i;
	assign sum_i = 33'(cmd.a_im) + 33'(cmd.b_im);
	assign dif_i = 33'(cmd.a_im) - 33'(cmd.b_im);

	always_comb begin
		entry.op      = cmd.opcode;
		entry.a_re    = cmd.a_re;
		entry.a_im    = cmd.a_im;
		entry.b_re    = cmd.b_re;
		entry.b_im    = cmd.b_im;
		entry.pow_neg = cmd.exponent[7];
		entry.pow_n   = cmd.exponent[7] ? 8'(-cmd.exponent) : 8'(cmd.exponent);
		entry.kind    = K_ITER;
		entry.qk_re   = '0;
		entry.qk_im   = '0;
		case (cmd.opcode)
			OP_ADD: begin
				entry.kind  = K_DIRECT;
				entry.qk_re = sat_w66(66'(sum));
				entry.qk_im = sat_w66(66'(sum_i));
			end
			OP_SUB: begin
				entry.kind  = K_DIRECT;
				entry.qk_re = sat_w66(66'(dif));
				entry.qk_im = sat_w66(66'(dif_i));
			end
			OP_NOP: begin
				entry.kind = K_DIRECT;
			end
			default: begin
				entry.kind = K_ITER;
			end
		endcase
	end

endmodule

// ===== rtl/cau_fifo.sv =====
module cau_fifo import cau_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cau_entry_t entry_in,
	input  logic       pop,
	output logic       full,
	output logic       valid,
	output cau_entry_t entry_out
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cau_entry_t      mem_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign valid     = (cnt_q != '0);
	assign entry_out = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= entry_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/cau_exec.sv =====
module cau_exec import cau_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cau_entry_t  q_entry,
	output logic        pop,
	output logic        done,
	output cau_result_t result,
	output cau_xstat_t  xstat
);

	localparam int unsigned NW = 64 + FRAC_BITS;
	localparam int unsigned DW = 96;
	localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

	cau_state_t st_q, st_d;

	cau_op_t            op_q;
	logic signed [31:0] a0_q, a1_q;
	logic [7:0]         pn_q;
	logic               pneg_q;
	logic [2:0]         pbit_q;
	logic signed [31:0] x0_q, x1_q, y0_q, y1_q;
	logic signed [31:0] r0_q, r1_q;
	logic [5:0]         cnt_q;
	logic signed [63:0] prod_q;
	logic signed [65:0] acc_re_q, acc_im_q, acc_dn_q;
	logic [63:0]        sq_v_q, sq_r_q;
	logic [NW-1:0]      dv_rem_q;
	logic [DW-1:0]      dv_dsh_q;
	logic [31:0]        dv_quo_q;
	logic               dv_ovf_q, dv_neg_q;
	cau_result_t        res_q;
	logic               done_q;

	// sequencer strobes
	logic               fin;
	cau_result_t        fin_res;
	logic               ld_in, ld_xy, ld_r, ld_sq, ld_dv, bit_dec;
	logic signed [31:0] nx0, nx1, ny0, ny1, nr0, nr1;
	logic [63:0]        nsq;
	logic [NW-1:0]      ndn;
	logic [63:0]        ndd;
	logic               ndneg;
	logic               cnt_clr;

	// multiply-accumulate unit
	logic               is_cmul, is_divn, is_norm, mac_on, mac_done;
	logic [2:0]         nk;
	logic [2:0]         mj;
	logic signed [31:0] mx, my;
	logic               acc_en, e_re, s_re, e_im, s_im, e_dn;
	logic signed [65:0] prodx;
	logic signed [31:0] cm_re, cm_im;
	logic               nre, nim;
	logic [63:0]        mre, mim, den;

	assign is_cmul = (st_q == S_MUL) || (st_q == S_PWSQ) || (st_q == S_PWMA);
	assign is_divn = (st_q == S_DIVN);
	assign is_norm = (st_q == S_NORM);
	assign mac_on  = is_cmul || is_divn || is_norm;
	assign nk      = is_divn ? 3'd6 : (is_norm ? 3'd2 : 3'd4);
	assign mac_done = mac_on && (cnt_q == {3'b0, nk} + 6'd1);
	assign acc_en  = mac_on && (cnt_q != '0) && (cnt_q <= {3'b0, nk});
	assign mj      = 3'(cnt_q - 6'd1);
	assign prodx   = 66'(prod_q);

	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin mx = x0_q; my = y0_q; end
			3'd1: begin mx = x1_q; my = y1_q; end
			3'd2: begin mx = x0_q; my = y1_q; end
			3'd3: begin mx = x1_q; my = y0_q; end
			3'd4: begin mx = y0_q; my = y0_q; end
			3'd5: begin mx = y1_q; my = y1_q; end
			default: begin mx = x0_q; my = y0_q; end
		endcase
	end

	// where each product goes
	always_comb begin
		e_re = 1'b0;
		s_re = 1'b0;
		e_im = 1'b0;
		s_im = 1'b0;
		e_dn = 1'b0;
		if (is_norm) begin
			e_dn = 1'b1;
		end else begin
			case (mj)
				3'd0: e_re = 1'b1;
				3'd1: begin e_re = 1'b1; s_re = ~is_divn; end
				3'd2: begin e_im = 1'b1; s_im = is_divn; end
				3'd3: e_im = 1'b1;
				3'd4, 3'd5: e_dn = is_divn;
				default: e_re = 1'b0;
			endcase
		end
	end

	assign cm_re = sat_w66(acc_re_q >>> FRAC_BITS);
	assign cm_im = sat_w66(acc_im_q >>> FRAC_BITS);
	assign nre   = acc_re_q[65];
	assign nim   = acc_im_q[65];
	assign mre   = nre ? 64'(-acc_re_q) : acc_re_q[63:0];
	assign mim   = nim ? 64'(-acc_im_q) : acc_im_q[63:0];
	assign den   = acc_dn_q[63:0];

	// integer square root, two bits per cycle
	logic        sq_on, sq_done;
	logic [63:0] sq_bit, sq_trial;
	assign sq_on    = (st_q == S_SQM) || (st_q == S_SQRE) || (st_q == S_SQIMS);
	assign sq_done  = sq_on && (cnt_q == 6'd32);
	assign sq_bit   = 64'h4000_0000_0000_0000 >> {cnt_q[4:0], 1'b0};
	assign sq_trial = sq_r_q + sq_bit;

	// restoring divider, one quotient bit per cycle after an overflow probe
	logic dv_on, dv_done, dv_ge;
	logic signed [31:0] dv_val;
	assign dv_on   = (st_q == S_DIVRE) || (st_q == S_DIVIM) || (st_q == S_SQIMD);
	assign dv_done = dv_on && (cnt_q == 6'd33);
	assign dv_ge   = (DW'(dv_rem_q) >= dv_dsh_q);
	assign dv_val  = sat_quot(dv_ovf_q, dv_neg_q, dv_quo_q);

	// operands for the root steps
	logic signed [65:0] tsum;
	logic [32:0]        a1m, na0;
	logic signed [31:0] sq_im;
	logic signed [65:0] sq_rv;
	assign tsum  = $signed({2'b0, sq_r_q}) + 66'(a0_q);
	assign a1m   = a1_q[31] ? 33'(-33'(a1_q)) : 33'(a1_q);
	assign na0   = 33'(-33'(a0_q));
	assign sq_rv = $signed({2'b0, sq_r_q});
	assign sq_im = sat_w66(a1_q[31] ? -sq_rv : sq_rv);

	// next state and sequencing
	always_comb begin
		st_d    = st_q;
		pop     = 1'b0;
		fin     = 1'b0;
		fin_res = '0;
		ld_in   = 1'b0;
		ld_xy   = 1'b0;
		ld_r    = 1'b0;
		ld_sq   = 1'b0;
		ld_dv   = 1'b0;
		bit_dec = 1'b0;
		nx0 = x0_q; nx1 = x1_q; ny0 = y0_q; ny1 = y1_q;
		nr0 = r0_q; nr1 = r1_q;
		nsq   = '0;
		ndn   = '0;
		ndd   = '0;
		ndneg = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					pop   = 1'b1;
					ld_in = 1'b1;
					if (q_entry.kind == K_DIRECT) begin
						fin            = 1'b1;
						fin_res.res_re = q_entry.qk_re;
						fin_res.res_im = q_entry.qk_im;
					end else begin
						case (q_entry.op)
							OP_MUL, OP_DIV: begin
								ld_xy = 1'b1;
								nx0 = q_entry.a_re; nx1 = q_entry.a_im;
								ny0 = q_entry.b_re; ny1 = q_entry.b_im;
								st_d = (q_entry.op == OP_MUL) ? S_MUL : S_DIVN;
							end
							OP_MOD, OP_SQRT: begin
								ld_xy = 1'b1;
								nx0 = q_entry.a_re; nx1 = q_entry.a_im;
								ny0 = q_entry.a_re; ny1 = q_entry.a_im;
								st_d = S_NORM;
							end
							OP_POW: begin
								ld_xy = 1'b1;
								ld_r  = 1'b1;
								nr0 = ONE_FX; nr1 = '0;
								nx0 = ONE_FX; nx1 = '0;
								ny0 = ONE_FX; ny1 = '0;
								st_d = S_PWSQ;
							end
							default: begin
								fin = 1'b1;
							end
						endcase
					end
				end
			end
			S_MUL: begin
				if (mac_done) begin
					fin            = 1'b1;
					fin_res.res_re = cm_re;
					fin_res.res_im = cm_im;
					st_d           = S_IDLE;
				end
			end
			S_DIVN: begin
				if (mac_done) begin
					if (den == '0) begin
						fin            = 1'b1;
						fin_res.status = 1'b1;
						st_d           = S_IDLE;
					end else begin
						ld_dv = 1'b1;
						ndn   = NW'(mre) << FRAC_BITS;
						ndd   = den;
						ndneg = nre;
						st_d  = S_DIVRE;
					end
				end
			end
			S_DIVRE: begin
				if (dv_done) begin
					ld_r  = 1'b1;
					nr0   = dv_val;
					ld_dv = 1'b1;
					ndn   = NW'(mim) << FRAC_BITS;
					ndd   = den;
					ndneg = nim;
					st_d  = S_DIVIM;
				end
			end
			S_DIVIM: begin
				if (dv_done) begin
					fin            = 1'b1;
					fin_res.res_re = r0_q;
					fin_res.res_im = dv_val;
					st_d           = S_IDLE;
				end
			end
			S_NORM: begin
				if (mac_done) begin
					ld_sq = 1'b1;
					nsq   = den;
					st_d  = S_SQM;
				end
			end
			S_SQM: begin
				if (sq_done) begin
					if (op_q == OP_MOD) begin
						fin            = 1'b1;
						fin_res.res_re = sat_w66(sq_rv);
						st_d           = S_IDLE;
					end else begin
						ld_sq = 1'b1;
						nsq   = tsum[63:0] << (FRAC_BITS - 1);
						st_d  = S_SQRE;
					end
				end
			end
			S_SQRE: begin
				if (sq_done) begin
					ld_r = 1'b1;
					nr0  = sq_r_q[31:0];
					if (sq_r_q != '0) begin
						ld_dv = 1'b1;
						ndn   = NW'(a1m) << FRAC_BITS;
						ndd   = sq_r_q << 1;
						ndneg = a1_q[31];
						st_d  = S_SQIMD;
					end else begin
						ld_sq = 1'b1;
						nsq   = 64'(na0) << FRAC_BITS;
						st_d  = S_SQIMS;
					end
				end
			end
			S_SQIMD, S_SQIMS: begin
				if ((st_q == S_SQIMD) ? dv_done : sq_done) begin
					fin            = 1'b1;
					fin_res.res_re = r0_q;
					fin_res.res_im = (st_q == S_SQIMD) ? dv_val : sq_im;
					fin_res.alt_re = neg_sat(r0_q);
					fin_res.alt_im = neg_sat(fin_res.res_im);
					st_d           = S_IDLE;
				end
			end
			S_PWSQ, S_PWMA: begin
				if (mac_done) begin
					ld_r = 1'b1;
					nr0  = cm_re;
					nr1  = cm_im;
					if ((st_q == S_PWSQ) && pn_q[pbit_q]) begin
						ld_xy = 1'b1;
						nx0 = a0_q; nx1 = a1_q; ny0 = cm_re; ny1 = cm_im;
						st_d = S_PWMA;
					end else if (pbit_q != '0) begin
						bit_dec = 1'b1;
						ld_xy   = 1'b1;
						nx0 = cm_re; nx1 = cm_im; ny0 = cm_re; ny1 = cm_im;
						st_d = S_PWSQ;
					end else if (pneg_q) begin
						ld_xy = 1'b1;
						nx0 = ONE_FX; nx1 = '0; ny0 = cm_re; ny1 = cm_im;
						st_d = S_DIVN;
					end else begin
						fin            = 1'b1;
						fin_res.res_re = cm_re;
						fin_res.res_im = cm_im;
						st_d           = S_IDLE;
					end
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	assign cnt_clr = (st_d != st_q) || ld_xy || ld_sq || ld_dv;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			cnt_q  <= cnt_clr ? '0 : cnt_q + 6'd1;
			done_q <= fin;
		end
	end

	// operand, result and sequencing payload
	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= fin_res;
		end
		if (ld_in) begin
			op_q   <= q_entry.op;
			a0_q   <= q_entry.a_re;
			a1_q   <= q_entry.a_im;
			pn_q   <= q_entry.pow_n;
			pneg_q <= q_entry.pow_neg;
			pbit_q <= 3'd7;
		end else if (bit_dec) begin
			pbit_q <= pbit_q - 3'd1;
		end
		if (ld_r) begin
			r0_q <= nr0;
			r1_q <= nr1;
		end
	end

	// multiply-accumulate datapath
	always_ff @(posedge clk) begin
		prod_q <= mx * my;
		if (ld_xy) begin
			x0_q     <= nx0;
			x1_q     <= nx1;
			y0_q     <= ny0;
			y1_q     <= ny1;
			acc_re_q <= '0;
			acc_im_q <= '0;
			acc_dn_q <= '0;
		end else if (acc_en) begin
			if (e_re) begin
				acc_re_q <= s_re ? acc_re_q - prodx : acc_re_q + prodx;
			end
			if (e_im) begin
				acc_im_q <= s_im ? acc_im_q - prodx : acc_im_q + prodx;
			end
			if (e_dn) begin
				acc_dn_q <= acc_dn_q + prodx;
			end
		end
	end

	// square root datapath
	always_ff @(posedge clk) begin
		if (ld_sq) begin
			sq_v_q <= nsq;
			sq_r_q <= '0;
		end else if (sq_on && !cnt_q[5]) begin
			if (sq_v_q >= sq_trial) begin
				sq_v_q <= sq_v_q - sq_trial;
				sq_r_q <= (sq_r_q >> 1) + sq_bit;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (ld_dv) begin
			dv_rem_q <= ndn;
			dv_dsh_q <= DW'(ndd) << 32;
			dv_quo_q <= '0;
			dv_neg_q <= ndneg;
			dv_ovf_q <= 1'b0;
		end else if (dv_on && (cnt_q <= 6'd32)) begin
			dv_dsh_q <= dv_dsh_q >> 1;
			if (cnt_q == '0) begin
				dv_ovf_q <= dv_ge;
			end else if (dv_ge) begin
				dv_rem_q <= dv_rem_q - NW'(dv_dsh_q);
				dv_quo_q <= {dv_quo_q[30:0], 1'b1};
			end else begin
				dv_quo_q <= {dv_quo_q[30:0], 1'b0};
			end
		end
	end

	assign done       = done_q;
	assign result     = res_q;
	assign xstat.idle = (st_q == S_IDLE);
	assign xstat.pop  = pop;

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// channel   | ports                | handshake
// ----------+----------------------+-------------------------------------------
// command   | start, busy, cmd     | transaction when start && !busy
// result    | done, result         | one-cycle strobe on done, cannot be held
//
// Add, subtract and opcode seven finish in the front, then pass through the queue and done register.
// Multiply: four products through the one 32x32 multiplier.
// Divide: six products, then two restoring divisions.
// Modulus: one 32-step root. Square root: two 32-step roots and a division or a
// third root. Power: up to 16 complex products, plus a division for a negative
// exponent.
// Reset clears the queue and the sequencer. busy is high while the queue is full;
// results leave on a strobe and the receiver cannot stall them.
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int unsigned FRAC_BITS   = 16,
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cau_item_t   cmd,
	output logic        done,
	output cau_result_t result
);

	logic       push, q_full, q_valid, pop;
	cau_entry_t f_entry, q_entry;
	cau_xstat_t xs;

	assign busy = q_full;

	cau_front u_front (
		.start (start),
		.full  (q_full),
		.cmd   (cmd),
		.push  (push),
		.entry (f_entry)
	);

	cau_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.entry_in  (f_entry),
		.pop       (pop),
		.full      (q_full),
		.valid     (q_valid),
		.entry_out (q_entry)
	);

	cau_exec #(
		.FRAC_BITS (FRAC_BITS)
	) u_exec (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.pop     (pop),
		.done    (done),
		.result  (result),
		.xstat   (xs)
	);

	// a divide-by-zero result carries only zeros
	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> (result.res_re == 0 && result.res_im == 0 &&
			result.alt_re == 0 && result.alt_im == 0))
		else $error("status set with nonzero result");

	// a result only follows a queued transaction or running work
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(xs.pop || !xs.idle))
		else $error("result strobe without work");

endmodule

// ===== tb/tb.sv =====
module tb;
	import cau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam longint ONE = longint'(1) << FRAC;
	localparam bit [63:0] LOW_MASK = (64'd1 << FRAC) - 64'd1;
	localparam int RANDOM_ITEMS = 400;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT = 500000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cau_item_t   cmd;
	logic        done;
	cau_result_t result;

	complex_arithmetic_unit DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.result(result)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	cau_result_t pending_results[$];
	int          mismatches;
	int          results_seen;
	int          cycles;
	int          op_count[8];

	// ---------------- predictor ----------------
	function automatic longint clamp32(longint v);
		if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
		if (v < -longint'(64'd2147483648)) return -longint'(64'd2147483648);
		return v;
	endfunction

	// magnitude and sign of p + q
	function automatic bit [63:0] mag_of_sum(longint p, longint q, output bit neg);
		bit [63:0] u;
		u = p + q;
		neg = u[63] && (u != (64'd1 << 63));
		return neg ? (64'd0 - u) : u;
	endfunction

	function automatic longint floor_frac(longint p, longint q);
		bit neg;
		bit [63:0] m;
		m = mag_of_sum(p, q, neg);
		if (!neg) return longint'(m >> FRAC);
		return -longint'((m + LOW_MASK) >> FRAC);
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] root;
		bit [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic void complex_mul(input longint xr, xi, yr, yi,
			output longint zr, zi);
		zr = clamp32(floor_frac(xr * yr, -(xi * yi)));
		zi = clamp32(floor_frac(xr * yi, xi * yr));
	endfunction

	function automatic longint frac_quotient(bit [63:0] mag, bit neg, bit [63:0] den);
		bit [63:0] qi;
		bit [63:0] rem;
		bit [63:0] frac;
		bit [63:0] q;
		qi = mag / den;
		rem = mag % den;
		frac = 0;
		if (qi > (64'd1 << (31 - FRAC)))
			return neg ? -longint'(64'd2147483648) : longint'(32'sh7FFF_FFFF);
		for (int i = 0; i < FRAC; i++) begin
			rem = rem << 1;
			frac = frac << 1;
			if (rem >= den) begin
				rem = rem - den;
				frac[0] = 1'b1;
			end
		end
		q = (qi << FRAC) | frac;
		return clamp32(neg ? -longint'(q) : longint'(q));
	endfunction

	// returns 1 on division by zero
	function automatic bit complex_div(longint xr, xi, yr, yi, output longint zr, zi);
		bit [63:0] den;
		bit [63:0] mre;
		bit [63:0] mim;
		bit nre;
		bit nim;
		den = 64'(yr * yr) + 64'(yi * yi);
		if (den == 0) begin
			zr = 0;
			zi = 0;
			return 1'b1;
		end
		mre = mag_of_sum(xr * yr, xi * yi, nre);
		mim = mag_of_sum(yr * xi, -(yi * xr), nim);
		zr = frac_quotient(mre, nre, den);
		zi = frac_quotient(mim, nim, den);
		return 1'b0;
	endfunction

	function automatic void complex_root(input longint xr, xi, output longint zr, zi);
		bit [63:0] m;
		bit [63:0] t;
		bit [63:0] re;
		bit [63:0] mag;
		longint im;
		m = int_sqrt(64'(xr * xr) + 64'(xi * xi));
		t = 64'(longint'(m) + xr);
		re = int_sqrt(t << (FRAC - 1));
		if (re != 0) begin
			mag = 64'(xi < 0 ? -xi : xi) << FRAC;
			im = longint'(mag / (64'd2 * re));
		end else begin
			im = longint'(int_sqrt(64'(-xr) << FRAC));
		end
		if (xi < 0) im = -im;
		zr = longint'(re);
		zi = clamp32(im);
	endfunction

	function automatic cau_result_t predict_result(cau_item_t it);
		longint ar, ai, br, bi, rr, ri, tr, ti, altr, alti;
		int n;
		bit st;
		ar = it.a_re;
		ai = it.a_im;
		br = it.b_re;
		bi = it.b_im;
		rr = 0;
		ri = 0;
		altr = 0;
		alti = 0;
		st = 1'b0;
		case (it.opcode)
			OP_ADD: begin
				rr = clamp32(ar + br);
				ri = clamp32(ai + bi);
			end
			OP_SUB: begin
				rr = clamp32(ar - br);
				ri = clamp32(ai - bi);
			end
			OP_MUL: complex_mul(ar, ai, br, bi, rr, ri);
			OP_DIV: st = complex_div(ar, ai, br, bi, rr, ri);
			OP_MOD: rr = clamp32(longint'(int_sqrt(64'(ar * ar) + 64'(ai * ai))));
			OP_SQRT: begin
				complex_root(ar, ai, rr, ri);
				altr = clamp32(-rr);
				alti = clamp32(-ri);
			end
			OP_POW: begin
				n = (it.exponent < 0) ? -int'(it.exponent) : int'(it.exponent);
				rr = ONE;
				ri = 0;
				// square-and-multiply, MSB first
				for (int b = 7; b >= 0; b--) begin
					complex_mul(rr, ri, rr, ri, tr, ti);
					rr = tr;
					ri = ti;
					if (n[b]) begin
						complex_mul(ar, ai, rr, ri, tr, ti);
						rr = tr;
						ri = ti;
					end
				end
				if (it.exponent < 0) begin
					st = complex_div(ONE, 0, rr, ri, tr, ti);
					rr = tr;
					ri = ti;
				end
			end
			default: ;
		endcase
		predict_result.res_re = rr[31:0];
		predict_result.res_im = ri[31:0];
		predict_result.alt_re = altr[31:0];
		predict_result.alt_im = alti[31:0];
		predict_result.status = st;
	endfunction

	// ---------------- result checking ----------------
	always @(posedge clk) begin
		cau_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result re=%h im=%h", $realtime,
						result.res_re, result.res_im);
			end else begin
				want = pending_results.pop_front();
				if (result.res_re !== want.res_re || result.res_im !== want.res_im ||
						result.alt_re !== want.alt_re || result.alt_im !== want.alt_im ||
						result.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp %h %h %h %h %b got %h %h %h %h %b",
							$realtime, want.res_re, want.res_im, want.alt_re,
							want.alt_im, want.status, result.res_re, result.res_im,
							result.alt_re, result.alt_im, result.status);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	typedef struct {
		cau_item_t   item;
		bit          typed;
		cau_result_t want;
	} directed_row_t;

	function automatic cau_item_t mk(cau_op_t op, logic [31:0] ar, ai, br, bi,
			logic [7:0] ex);
		mk.opcode = op;
		mk.a_re = ar;
		mk.a_im = ai;
		mk.b_re = br;
		mk.b_im = bi;
		mk.exponent = ex;
	endfunction

	function automatic cau_result_t rs(logic [31:0] r, i, logic s);
		rs.res_re = r;
		rs.res_im = i;
		rs.alt_re = '0;
		rs.alt_im = '0;
		rs.status = s;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		endcase
	endfunction

	// one transaction: hold start until accepted, then an optional gap
	task automatic send_cmd(cau_item_t it, bit typed, cau_result_t want);
		int gap;
		start <= 1'b1;
		cmd <= it;
		do @(posedge clk); while (busy);
		pending_results.push_back(typed ? want : predict_result(it));
		op_count[it.opcode]++;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		directed_row_t rows[$];
		cau_item_t it;
		mismatches = 0;
		results_seen = 0;
		cycles = 0;
		foreach (op_count[i]) op_count[i] = 0;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{mk(OP_ADD, 0, 0, 0, 0, 0), 1, rs(0, 0, 0)});
		rows.push_back('{mk(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 8'h7F), 1, rs(32'h7FFF_FFFF, 32'h8000_0000, 0)});
		rows.push_back('{mk(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 8'h80), 1, rs(32'h8000_0000, 32'h7FFF_FFFF, 0)});
		rows.push_back('{mk(OP_MUL, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000,
			32'h0003_8000, 0), 0, rs(0, 0, 0)});
		rows.push_back('{mk(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 0), 0, rs(0, 0, 0)});
		// division by zero
		rows.push_back('{mk(OP_DIV, 32'h0001_0000, 32'h0002_0000, 0, 0, 0), 1,
			rs(0, 0, 1)});
		rows.push_back('{mk(OP_DIV, 32'h0005_0000, 32'hFFFD_0000, 32'h0001_8000,
			32'h0000_4000, 0), 0, rs(0, 0, 0)});
		rows.push_back('{mk(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h0000_0001, 0),
			0, rs(0, 0, 0)});
		rows.push_back('{mk(OP_MOD, 32'h0003_0000, 32'h0004_0000, 0, 0, 0), 1,
			rs(32'h0005_0000, 0, 0)});
		rows.push_back('{mk(OP_MOD, 32'h8000_0000, 32'h8000_0000, 0, 0, 0), 0,
			rs(0, 0, 0)});
		rows.push_back('{mk(OP_SQRT, 0, 0, 0, 0, 0), 1, rs(0, 0, 0)});
		// roots on or near the negative real axis, with a zero and a negative imaginary part
		rows.push_back('{mk(OP_SQRT, 32'hFFFC_0000, 0, 0, 0, 0), 0, rs(0, 0, 0)});
		rows.push_back('{mk(OP_SQRT, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0), 0,
			rs(0, 0, 0)});
		rows.push_back('{mk(OP_SQRT, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0), 0,
			rs(0, 0, 0)});
		rows.push_back('{mk(OP_SQRT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0), 0,
			rs(0, 0, 0)});
		// zero power is one, even for a zero base
		rows.push_back('{mk(OP_POW, 0, 0, 0, 0, 0), 1, rs(32'h0001_0000, 0, 0)});
		rows.push_back('{mk(OP_POW, 32'h0000_8000, 32'h0000_8000, 0, 0, 8'h80), 0,
			rs(0, 0, 0)});
		rows.push_back('{mk(OP_POW, 32'h0001_0000, 32'h0000_4000, 0, 0, 8'h7F), 0,
			rs(0, 0, 0)});
		// negative power of zero
		rows.push_back('{mk(OP_POW, 0, 0, 0, 0, 8'hFD), 1, rs(0, 0, 1)});
		rows.push_back('{mk(OP_POW, 32'h0001_8000, 32'hFFFF_0000, 0, 0, 8'hFE), 0,
			rs(0, 0, 0)});
		rows.push_back('{mk(OP_NOP, 32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 8'hFF), 1, rs(0, 0, 0)});

		foreach (rows[i]) send_cmd(rows[i].item, rows[i].typed, rows[i].want);

		// random part
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			it.opcode = cau_op_t'($urandom_range(0, 7));
			it.a_re = rand_operand();
			it.a_im = rand_operand();
			it.b_re = rand_operand();
			it.b_im = rand_operand();
			if ($urandom_range(0, 3) == 0)
				it.exponent = 8'($urandom);
			else
				it.exponent = 8'($signed($urandom_range(0, 12)) - 6);
			send_cmd(it, 1'b0, '0);
		end
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands sent, %0d results checked, %0d mismatches",
			RANDOM_ITEMS + rows.size(), results_seen, mismatches);
		$display("per opcode add..nop: %0d %0d %0d %0d %0d %0d %0d %0d", op_count[0],
			op_count[1], op_count[2], op_count[3], op_count[4], op_count[5],
			op_count[6], op_count[7]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
